[design/cde_pkg.sv]
// ----------------------------------------------------------------------------
// cde_pkg
// Shared types and constants for the circular deque engine: capacity and
// derived widths, operation and status codes, cell commands, control states.
// ----------------------------------------------------------------------------
`default_nettype none

package cde_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int DATA_W   = 32;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_DUMP       = 3'd4;

    localparam logic [1:0] STS_DONE      = 2'd0;
    localparam logic [1:0] STS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STS_UNDERFLOW = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT,
        CELL_PUT_BACK,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [DATA_W-1:0]  value;
        logic [IDX_W-1:0]          sel;
    } t_chain_cmd;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

endpackage

`default_nettype wire

[design/cde_cell.sv]
// ----------------------------------------------------------------------------
// cde_cell
// One position of the deque row: holds one entry and loads it from its left
// neighbor, its right neighbor, the pushed value or the front entry.
// ----------------------------------------------------------------------------
`default_nettype none

module cde_cell (
    input  wire                             i_clk,
    input  cde_pkg::t_cell_op               i_op,
    input  wire                             i_match,
    input  wire signed [cde_pkg::DATA_W-1:0] i_value,
    input  wire signed [cde_pkg::DATA_W-1:0] i_left,
    input  wire signed [cde_pkg::DATA_W-1:0] i_right,
    input  wire signed [cde_pkg::DATA_W-1:0] i_wrap,
    output logic signed [cde_pkg::DATA_W-1:0] o_data
);

    logic signed [cde_pkg::DATA_W-1:0] r_data;
    logic signed [cde_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_op)
            cde_pkg::CELL_HOLD:       n_data = r_data;
            cde_pkg::CELL_TAKE_LEFT:  n_data = i_left;
            cde_pkg::CELL_TAKE_RIGHT: n_data = i_right;
            cde_pkg::CELL_PUT_BACK:   n_data = i_match ? i_value : r_data;
            // tail cell closes the ring with the front entry
            cde_pkg::CELL_ROTATE:     n_data = i_match ? i_wrap : i_right;
            default:                  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[design/cde_chain.sv]
// ----------------------------------------------------------------------------
// cde_chain
// Row of deque cells, front at position zero. Wires each cell to its
// neighbors and decodes the selected position for back pushes and rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module cde_chain (
    input  wire                               i_clk,
    input  cde_pkg::t_chain_cmd               i_cmd,
    output logic signed [cde_pkg::DATA_W-1:0] o_head
);

    logic signed [cde_pkg::DATA_W-1:0] w_data [cde_pkg::CAPACITY];

    for (genvar g = 0; g < cde_pkg::CAPACITY; g++) begin : g_cell
        logic                              w_match;
        logic signed [cde_pkg::DATA_W-1:0] w_left;
        logic signed [cde_pkg::DATA_W-1:0] w_right;

        assign w_match = (i_cmd.sel == cde_pkg::IDX_W'(g));

        if (g == 0) begin : g_first
            assign w_left = i_cmd.value;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == cde_pkg::CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        cde_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (i_cmd.op),
            .i_match (w_match),
            .i_value (i_cmd.value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_wrap  (w_data[0]),
            .o_data  (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

`default_nettype wire

[design/circular_deque_engine.sv]
// ----------------------------------------------------------------------------
// circular_deque_engine
// Bounded double-ended queue of signed 32-bit entries held in a row of
// shifting cells, with push/pop at both ends and a front-to-back dump.
// ----------------------------------------------------------------------------
//
//   channel   valid        ready        payload
//   input     i_in_valid   o_in_ready   i_operation, i_value
//   output    o_out_valid  i_out_ready  o_status, o_entry_value, o_last
//
// a dump takes the request and then makes one rotation of the cell row per
// entry, after which the row is back in order.
// the input is taken only in idle with the result register free or draining.
// a stalled output holds its result and the dump waits with it.
// reset clears the count and control; cell contents need no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque_engine (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire [2:0]                         i_operation,
    input  wire signed [cde_pkg::DATA_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [1:0]                        o_status,
    output logic signed [cde_pkg::DATA_W-1:0] o_entry_value,
    output logic                              o_last
);

    cde_pkg::t_state                   r_state, n_state;
    logic [cde_pkg::CNT_W-1:0]         r_count, n_count;
    logic [cde_pkg::IDX_W-1:0]         r_k, n_k;
    logic                              r_out_valid;
    logic [1:0]                        r_status;
    logic signed [cde_pkg::DATA_W-1:0] r_entry;
    logic                              r_last;

    logic                              w_slot_free;
    logic                              w_in_acc;
    logic                              w_full;
    logic                              w_empty;
    logic                              w_dump_last;
    logic signed [cde_pkg::DATA_W-1:0] w_head;
    cde_pkg::t_chain_cmd               w_cmd;

    logic                              res_load;
    logic [1:0]                        res_status;
    logic signed [cde_pkg::DATA_W-1:0] res_entry;
    logic                              res_last;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == cde_pkg::S_IDLE) && w_slot_free;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_full      = (r_count == cde_pkg::CNT_W'(cde_pkg::CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_dump_last = ((cde_pkg::CNT_W'(r_k) + cde_pkg::CNT_W'(1)) == r_count);

    cde_chain u_chain (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .o_head (w_head)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cde_pkg::S_IDLE: begin
                if (w_in_acc && (i_operation == cde_pkg::OP_DUMP) && !w_empty) begin
                    n_state = cde_pkg::S_DUMP;
                end
            end
            cde_pkg::S_DUMP: begin
                if (w_slot_free && w_dump_last) begin
                    n_state = cde_pkg::S_IDLE;
                end
            end
            default: n_state = cde_pkg::S_IDLE;
        endcase
    end

    // cell commands, count and result
    always_comb begin
        w_cmd.op    = cde_pkg::CELL_HOLD;
        w_cmd.value = i_value;
        w_cmd.sel   = '0;
        n_count     = r_count;
        n_k         = r_k;
        res_load    = 1'b0;
        res_status  = cde_pkg::STS_DONE;
        res_entry   = '0;
        res_last    = 1'b1;
        unique case (r_state)
            cde_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_operation)
                        cde_pkg::OP_PUSH_FRONT: begin
                            res_load = 1'b1;
                            if (w_full) begin
                                res_status = cde_pkg::STS_OVERFLOW;
                            end else begin
                                w_cmd.op = cde_pkg::CELL_TAKE_LEFT;
                                n_count  = r_count + cde_pkg::CNT_W'(1);
                            end
                        end
                        cde_pkg::OP_PUSH_BACK: begin
                            res_load = 1'b1;
                            if (w_full) begin
                                res_status = cde_pkg::STS_OVERFLOW;
                            end else begin
                                w_cmd.op  = cde_pkg::CELL_PUT_BACK;
                                w_cmd.sel = r_count[cde_pkg::IDX_W-1:0];
                                n_count   = r_count + cde_pkg::CNT_W'(1);
                            end
                        end
                        cde_pkg::OP_POP_FRONT: begin
                            res_load = 1'b1;
                            if (w_empty) begin
                                res_status = cde_pkg::STS_UNDERFLOW;
                            end else begin
                                w_cmd.op = cde_pkg::CELL_TAKE_RIGHT;
                                n_count  = r_count - cde_pkg::CNT_W'(1);
                            end
                        end
                        cde_pkg::OP_POP_BACK: begin
                            res_load = 1'b1;
                            if (w_empty) begin
                                res_status = cde_pkg::STS_UNDERFLOW;
                            end else begin
                                n_count = r_count - cde_pkg::CNT_W'(1);
                            end
                        end
                        cde_pkg::OP_DUMP: begin
                            if (w_empty) begin
                                res_load   = 1'b1;
                                res_status = cde_pkg::STS_UNDERFLOW;
                            end else begin
                                n_k = '0;
                            end
                        end
                        default: begin
                            // unused codes: request taken, nothing changes
                        end
                    endcase
                end
            end
            cde_pkg::S_DUMP: begin
                if (w_slot_free) begin
                    res_load  = 1'b1;
                    res_entry = w_head;
                    res_last  = w_dump_last;
                    w_cmd.op  = cde_pkg::CELL_ROTATE;
                    w_cmd.sel = cde_pkg::IDX_W'(r_count - cde_pkg::CNT_W'(1));
                    n_k       = r_k + cde_pkg::IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cde_pkg::S_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_k     <= n_k;
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_status <= res_status;
            r_entry  <= res_entry;
            r_last   <= res_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_value = r_entry;
    assign o_last        = r_last;

endmodule

`default_nettype wire
